@@ design/pwc_pkg.sv @@
// ============================================================================
// PWM pulse-width capture: shared package
// Types, sizes and codes used by the capture table, its row memory and its
// update logic.
// ============================================================================
package pwc_pkg;

    // Table geometry and field widths
    localparam int NUM_TIMERS         = 8;
    localparam int CHANNELS_PER_TIMER = 4;
    localparam int COUNTER_BITS       = 16;
    localparam int TIMER_BITS         = 3;
    localparam int CHAN_BITS          = 2;
    localparam int WIDTH_BITS         = 16;
    localparam int STAMP_BITS         = 32;
    localparam int MASK_BITS          = 8;
    localparam int TMASK_BITS         = 4;

    // Register reset values
    localparam logic [COUNTER_BITS-1:0] COUNTER_TOP_RESET = 16'd4000;
    localparam logic [STAMP_BITS-1:0]   TIMEOUT_RESET     = 32'd100000;
    localparam logic [MASK_BITS-1:0]    CAPTURE_MASK_RESET = 8'h0f;

    typedef enum logic [1:0] {
        OP_ARM      = 2'd0,
        OP_EDGE     = 2'd1,
        OP_OVERFLOW = 2'd2,
        OP_READ     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_RISE = 2'd1,
        PH_FALL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_COUNTER_TOP  = 2'd0,
        CFG_TIMEOUT      = 2'd1,
        CFG_CAPTURE_MASK = 2'd2
    } cfg_idx_t;

    // One capture channel as held in the table
    typedef struct packed {
        phase_t                  phase;
        logic [COUNTER_BITS-1:0] rise;
        logic [COUNTER_BITS-1:0] fall;
        logic [WIDTH_BITS-1:0]   width;
        logic [STAMP_BITS-1:0]   stamp;
        logic [WIDTH_BITS-1:0]   fallback;
    } chan_t;

    // One memory entry holds all channels of a timer
    typedef chan_t [CHANNELS_PER_TIMER-1:0] entry_t;

    // Write request into the row memory
    typedef struct packed {
        logic                  en;
        logic [TIMER_BITS-1:0] addr;
        entry_t                data;
    } wr_req_t;

    // One input item
    typedef struct packed {
        opcode_t                 opcode;
        logic [TIMER_BITS-1:0]   timer_index;
        logic [CHAN_BITS-1:0]    channel_index;
        logic [COUNTER_BITS-1:0] edge_time;
        logic [STAMP_BITS-1:0]   time_now;
        logic [WIDTH_BITS-1:0]   default_value;
    } item_t;

    // One result item
    typedef struct packed {
        logic [WIDTH_BITS-1:0] width;
        logic                  channel_active;
        logic [TMASK_BITS-1:0] timed_out_mask;
        logic                  rejected;
    } result_t;

    function automatic logic is_active(input phase_t ph);
        return (ph == PH_RISE) || (ph == PH_FALL);
    endfunction

endpackage

@@ design/pwc_row_mem.sv @@
// ============================================================================
// PWM pulse-width capture: row memory
// One entry per timer, registered synchronous read, with per-entry valid bits
// so that unwritten entries read as zero, and write-to-read forwarding.
// ============================================================================
module pwc_row_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pwc_pkg::TIMER_BITS-1:0] rd_addr,
    input  pwc_pkg::wr_req_t              wr_req,
    output pwc_pkg::entry_t               rd_entry
);

    pwc_pkg::entry_t                        mem [pwc_pkg::NUM_TIMERS];
    pwc_pkg::entry_t                        rd_data_reg;
    pwc_pkg::entry_t                        fwd_data_reg;
    logic [pwc_pkg::NUM_TIMERS-1:0]         vld_reg;
    logic                                   rd_vld_reg;
    logic                                   fwd_hit_reg;
    logic                                   same_addr;

    assign same_addr = wr_req.en && (wr_req.addr == rd_addr);

    // Storage array and registered read port
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr] <= wr_req.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_req.data;
    end

    // Valid bits and forwarding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (wr_req.en) begin
                vld_reg[wr_req.addr] <= 1'b1;
            end
            rd_vld_reg  <= vld_reg[rd_addr];
            fwd_hit_reg <= same_addr;
        end
    end

    // A write in the read cycle wins; an unwritten entry reads as all zero.
    always_comb begin
        if (fwd_hit_reg) begin
            rd_entry = fwd_data_reg;
        end else if (rd_vld_reg) begin
            rd_entry = rd_data_reg;
        end else begin
            rd_entry = '0;
        end
    end

endmodule

@@ design/pwc_update.sv @@
// ============================================================================
// PWM pulse-width capture: entry update
// Computes the new timer entry and the result item for one input item from
// the entry read out of the row memory.
// ============================================================================
module pwc_update (
    input  pwc_pkg::item_t                    item,
    input  pwc_pkg::entry_t                   old_entry,
    input  logic [pwc_pkg::COUNTER_BITS-1:0]  counter_top,
    input  logic [pwc_pkg::STAMP_BITS-1:0]    timeout_ticks,
    input  logic [pwc_pkg::MASK_BITS-1:0]     capture_mask,
    output pwc_pkg::entry_t                   new_entry,
    output pwc_pkg::result_t                  result
);

    pwc_pkg::chan_t                           cur;
    pwc_pkg::chan_t                           sel;
    logic [pwc_pkg::STAMP_BITS-1:0]           age [pwc_pkg::CHANNELS_PER_TIMER];
    logic [pwc_pkg::CHANNELS_PER_TIMER-1:0]   expired;
    logic [pwc_pkg::COUNTER_BITS-1:0]         et;
    logic                                     may_arm;

    assign cur     = old_entry[item.channel_index];
    assign et      = item.edge_time;
    assign may_arm = capture_mask[item.timer_index];

    // Age of each channel's last edge against the timeout, one lane each
    always_comb begin
        for (int c = 0; c < pwc_pkg::CHANNELS_PER_TIMER; c++) begin
            age[c]     = item.time_now - old_entry[c].stamp;
            expired[c] = pwc_pkg::is_active(old_entry[c].phase) &&
                         (age[c] > timeout_ticks);
        end
    end

    // Apply the operation to the entry
    always_comb begin
        new_entry = old_entry;
        result    = '0;
        case (item.opcode)
            pwc_pkg::OP_ARM: begin
                if (may_arm) begin
                    new_entry[item.channel_index].rise     = '0;
                    new_entry[item.channel_index].fall     = '0;
                    new_entry[item.channel_index].width    = '0;
                    new_entry[item.channel_index].fallback = item.default_value;
                    new_entry[item.channel_index].phase    = pwc_pkg::PH_RISE;
                end else begin
                    result.rejected = 1'b1;
                end
            end
            pwc_pkg::OP_EDGE: begin
                if (pwc_pkg::is_active(cur.phase)) begin
                    new_entry[item.channel_index].stamp = item.time_now;
                    if (cur.phase == pwc_pkg::PH_RISE) begin
                        new_entry[item.channel_index].rise  = et;
                        new_entry[item.channel_index].phase = pwc_pkg::PH_FALL;
                    end else begin
                        new_entry[item.channel_index].fall  = et;
                        // A fall at or before the rise wraps through the top.
                        if (et > cur.rise) begin
                            new_entry[item.channel_index].width = et - cur.rise;
                        end else begin
                            new_entry[item.channel_index].width =
                                counter_top - cur.rise + et;
                        end
                        new_entry[item.channel_index].phase = pwc_pkg::PH_RISE;
                    end
                end
            end
            pwc_pkg::OP_OVERFLOW: begin
                for (int c = 0; c < pwc_pkg::CHANNELS_PER_TIMER; c++) begin
                    if (expired[c]) begin
                        new_entry[c].rise  = '0;
                        new_entry[c].fall  = '0;
                        new_entry[c].width = old_entry[c].fallback;
                        new_entry[c].phase = pwc_pkg::PH_RISE;
                    end
                end
                result.timed_out_mask = expired;
            end
            pwc_pkg::OP_READ: begin
                new_entry = old_entry;
            end
            default: begin
                new_entry = old_entry;
            end
        endcase
        // Report the addressed channel after the update.
        sel                   = new_entry[item.channel_index];
        result.width          = sel.width;
        result.channel_active = pwc_pkg::is_active(sel.phase);
    end

endmodule

@@ design/pwm_pulse_width_capture.sv @@
// ============================================================================
// PWM pulse-width capture
// Table of capture channels per timer: arm, edge capture, timeout fallback
// and width read, one result item for each input item.
// ============================================================================
// Usage:
//   The input stream carries one item per transfer: s_tuser holds the
//   opcode (arm, edge, overflow check, read), s_tdata the timer, channel,
//   edge time, timestamp and default width. Every item gives exactly one
//   result transfer on the m_ stream: the addressed channel's width and
//   active flag, the channels that timed out and the arm-rejected flag.
//   The cfg_ channel writes counter_top, timeout_ticks and the capture timer
//   mask; it is always ready and must only be used while the block is idle.
//   An item waits in the stage register and its result in the output
//   register before the result is valid. One item is taken every cycle
//   while the receiver takes results: each item does one read-modify-write of
//   its timer's memory entry, and a write that lands while the next read is
//   in flight is forwarded, so one memory read and one write per cycle set that rate.
//   Reset clears the valid bits of all entries, so every channel starts
//   disabled with zero state; no clearing pass is needed. When the receiver
//   stalls, one result waits in the output register and one item waits in
//   the stage register; then s_tready drops until the result is taken.
// ============================================================================
module pwm_pulse_width_capture (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: timer_index[3], channel_index[2], edge_time[16],
    // time_now[32], default_value[16], zero fill[3]
    input  logic [71:0] s_tdata,
    // s_tuser: opcode[2]
    input  logic [1:0]  s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: width[16], channel_active[1], timed_out_mask[4],
    // rejected[1], zero fill[2]
    output logic [23:0] m_tdata,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [pwc_pkg::COUNTER_BITS-1:0] counter_top_reg;
    logic [pwc_pkg::STAMP_BITS-1:0]   timeout_reg;
    logic [pwc_pkg::MASK_BITS-1:0]    capture_mask_reg;

    pwc_pkg::item_t                   in_item;
    pwc_pkg::item_t                   st_item_reg;
    logic                             st_valid_reg;
    logic                             out_valid_reg;
    pwc_pkg::result_t                 out_res_reg;
    logic                             advance;
    logic                             in_xfer;
    logic [pwc_pkg::TIMER_BITS-1:0]   rd_addr;
    pwc_pkg::entry_t                  rd_entry;
    pwc_pkg::entry_t                  new_entry;
    pwc_pkg::result_t                 result;
    pwc_pkg::wr_req_t                 wr_req;

    // Unpack the input transfer
    assign in_item.opcode        = pwc_pkg::opcode_t'(s_tuser);
    assign in_item.timer_index   = s_tdata[2:0];
    assign in_item.channel_index = s_tdata[4:3];
    assign in_item.edge_time     = s_tdata[20:5];
    assign in_item.time_now      = s_tdata[52:21];
    assign in_item.default_value = s_tdata[68:53];

    // Handshake: the stage moves on when the output register is free or taken
    assign advance   = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !st_valid_reg || advance;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_top_reg  <= pwc_pkg::COUNTER_TOP_RESET;
            timeout_reg      <= pwc_pkg::TIMEOUT_RESET;
            capture_mask_reg <= pwc_pkg::CAPTURE_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == pwc_pkg::CFG_COUNTER_TOP) begin
                counter_top_reg <= cfg_data[pwc_pkg::COUNTER_BITS-1:0];
            end
            if (cfg_index == pwc_pkg::CFG_TIMEOUT) begin
                timeout_reg <= cfg_data;
            end
            if (cfg_index == pwc_pkg::CFG_CAPTURE_MASK) begin
                capture_mask_reg <= cfg_data[pwc_pkg::MASK_BITS-1:0];
            end
        end
    end

    // Read the incoming item's entry, or re-read the held item's entry
    assign rd_addr = s_tready ? in_item.timer_index : st_item_reg.timer_index;

    // Stage register: item whose entry is being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            st_item_reg <= in_item;
        end
    end

    pwc_row_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .wr_req   (wr_req),
        .rd_entry (rd_entry)
    );

    pwc_update u_update (
        .item          (st_item_reg),
        .old_entry     (rd_entry),
        .counter_top   (counter_top_reg),
        .timeout_ticks (timeout_reg),
        .capture_mask  (capture_mask_reg),
        .new_entry     (new_entry),
        .result        (result)
    );

    // Write the updated entry back as the item leaves the stage
    assign wr_req.en   = advance;
    assign wr_req.addr = st_item_reg.timer_index;
    assign wr_req.data = new_entry;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.rejected, out_res_reg.timed_out_mask,
                       out_res_reg.channel_active, out_res_reg.width};

endmodule

@@ design/pwc_checker.sv @@
// ============================================================================
// PWM pulse-width capture: port checker
// Assertions on what the top level's ports show over time.
// ============================================================================
module pwc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // No result is shown right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A disabled channel has never been armed, so its width is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("inactive channel with nonzero width");

    // A rejected arm never reports timed-out channels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[20:17] == 4'd0)
        else $error("rejected item with timeout mask");

    // A result can only follow an earlier input transfer or a held one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 1))
        else $error("result without input transfer");

endmodule

bind pwm_pulse_width_capture pwc_checker u_pwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
